/* rtl/pngunf_pkg.sv */
package pngunf_pkg;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int BPP_W     = 4;
    localparam int ROWB_W    = 14;
    localparam int ROWS_W    = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;

    // Filter types of filter method 0
    typedef enum logic [7:0] {
        FILT_NONE  = 8'd0,
        FILT_SUB   = 8'd1,
        FILT_UP    = 8'd2,
        FILT_AVG   = 8'd3,
        FILT_PAETH = 8'd4
    } t_filter;

    // Result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } t_out;

    // Row filter and neighbors handed to the predictor
    typedef struct packed {
        logic [7:0] filt;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_nbr;

endpackage

/* rtl/pngunf_stream_if.sv */
interface pngunf_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pngunf_pred.sv */
module pngunf_pred import pngunf_pkg::*; (
    input  t_nbr       i_nbr,
    input  logic [7:0] i_x,
    output logic [7:0] o_res
);

    logic signed [9:0] d_ac;
    logic signed [9:0] d_bc;
    logic signed [9:0] d_abc;
    logic [9:0]        da;
    logic [9:0]        db;
    logic [9:0]        dc;
    logic [7:0]        paeth;
    logic [8:0]        avg_sum;
    logic [7:0]        pred;

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    always_comb begin
        d_ac  = $signed({2'b00, i_nbr.a}) - $signed({2'b00, i_nbr.c});
        d_bc  = $signed({2'b00, i_nbr.b}) - $signed({2'b00, i_nbr.c});
        d_abc = d_ac + d_bc;
        da    = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
        db    = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
        dc    = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);
        priority if (da <= db && da <= dc) begin
            paeth = i_nbr.a;
        end else if (db <= dc) begin
            paeth = i_nbr.b;
        end else begin
            paeth = i_nbr.c;
        end
    end

    // Select prediction; unknown types predict zero
    always_comb begin
        avg_sum = {1'b0, i_nbr.a} + {1'b0, i_nbr.b};
        unique case (i_nbr.filt)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = i_nbr.a;
            FILT_UP:    pred = i_nbr.b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
    end

    assign o_res = i_x + pred;

endmodule

/* rtl/pngunf_line.sv */
module pngunf_line #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;
    logic       r_byp;
    logic [7:0] r_byp_data;

    // Write one byte, read one byte, registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    // Forward a write that hits the address being read
    always_ff @(posedge i_clk) begin
        r_byp      <= i_we && (i_waddr == i_raddr);
        r_byp_data <= i_wdata;
    end

    assign o_rdata = r_byp ? r_byp_data : r_q;

endmodule

/* rtl/png_scanline_unfilter.sv */
// An accepted byte is held in the input register, and its result word in the output
// register; an output word not taken stalls the next byte in the input register.
// Throughput: one byte per cycle unless output stalls; the line store is read one
// column ahead through its registered read port, so the above byte is ready when the
// byte arrives. Reset (synchronous, active low): configuration registers return to 1,
// the block waits for a filter-type byte of row 0; the line store is not cleared.
module png_scanline_unfilter import pngunf_pkg::*; #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pngunf_stream_if.sink        i_in,
    pngunf_stream_if.source      o_out
);

    localparam int COL_W = $clog2(MAX_ROW_BYTES);
    localparam int CMP_W = (COL_W + 1 > ROWS_W + 1) ? COL_W + 1 : ROWS_W + 1;
    localparam int WIN_W = 8 * MAX_PIXEL_BYTES;
    localparam int SEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_ROW_BYTES);
    localparam logic [BPP_W-1:0] MAX_BPP = BPP_W'(MAX_PIXEL_BYTES);

    // Configuration registers
    logic [BPP_W-1:0]  r_bpp;
    logic [ROWB_W-1:0] r_row_bytes;
    logic [ROWS_W-1:0] r_image_rows;

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // Row state
    logic              r_await;
    logic [7:0]        r_filter;
    logic [COL_W-1:0]  r_col;
    logic [ROWS_W-1:0] r_row;
    logic [WIN_W-1:0]  r_left;
    logic [WIN_W-1:0]  r_upleft;

    // Output register
    logic r_out_vld;
    t_out r_out;

    logic [COL_W-1:0]  n_col;
    logic [BPP_W-1:0]  bpp_eff;
    logic [SEL_W-1:0]  sel;
    logic [CMP_W-1:0]  len_eff;
    logic [CMP_W-1:0]  rows_eff;
    logic [CMP_W-1:0]  col_p1;
    logic [CMP_W-1:0]  row_p1;
    logic              last_col;
    logic              last_row;
    logic              proc_fire;
    logic [7:0]        above;
    logic [7:0]        res;
    t_nbr              nbr;

    assign proc_fire   = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !r_in_vld || proc_fire;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // Clamp registers to their working ranges
    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (r_bpp > MAX_BPP) begin
            bpp_eff = MAX_BPP;
        end else begin
            bpp_eff = r_bpp;
        end
        sel = SEL_W'(bpp_eff - BPP_W'(1));

        if (r_row_bytes == '0) begin
            len_eff = CMP_W'(1);
        end else if (CMP_W'(r_row_bytes) > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = CMP_W'(r_row_bytes);
        end

        rows_eff = (r_image_rows == '0) ? CMP_W'(1) : CMP_W'(r_image_rows);
    end

    // Gather neighbors and find row and image ends
    always_comb begin
        col_p1   = CMP_W'(r_col) + CMP_W'(1);
        row_p1   = CMP_W'(r_row) + CMP_W'(1);
        last_col = col_p1 >= len_eff;
        last_row = last_col && (row_p1 >= rows_eff);

        nbr.filt = r_filter;
        nbr.b    = (r_row != '0) ? above : 8'd0;
        if (CMP_W'(r_col) >= CMP_W'(bpp_eff)) begin
            nbr.a = r_left[sel*8 +: 8];
            nbr.c = (r_row != '0) ? r_upleft[sel*8 +: 8] : 8'd0;
        end else begin
            nbr.a = 8'd0;
            nbr.c = 8'd0;
        end

        if (!proc_fire) begin
            n_col = r_col;
        end else if (r_await || last_col) begin
            n_col = '0;
        end else begin
            n_col = COL_W'(col_p1);
        end
    end

    pngunf_pred u_pred (
        .i_nbr (nbr),
        .i_x   (r_in_byte),
        .o_res (res)
    );

    // Previous row; read address runs with the next column
    pngunf_line #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (COL_W)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (proc_fire && !r_await),
        .i_waddr (r_col),
        .i_wdata (res),
        .i_raddr (n_col),
        .o_rdata (above)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp        <= BPP_W'(1);
            r_row_bytes  <= ROWB_W'(1);
            r_image_rows <= ROWS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BPP:        r_bpp        <= i_cfg_data[BPP_W-1:0];
                CFG_ROW_BYTES:  r_row_bytes  <= i_cfg_data[ROWB_W-1:0];
                CFG_IMAGE_ROWS: r_image_rows <= i_cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Take an input word whenever the input register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (proc_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data;
        end
    end

    // Advance row state on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_filter <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= '0;
            r_upleft <= '0;
        end else if (proc_fire) begin
            r_col <= n_col;
            if (r_await) begin
                r_filter <= r_in_byte;
                r_left   <= '0;
                r_upleft <= '0;
                r_await  <= 1'b0;
            end else begin
                r_left   <= (r_left << 8) | WIN_W'(res);
                r_upleft <= (r_upleft << 8) | WIN_W'(nbr.b);
                if (last_col) begin
                    r_await <= 1'b1;
                    r_row   <= last_row ? '0 : ROWS_W'(row_p1);
                end
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_fire && !r_await) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && !r_await) begin
            r_out.out_byte   <= res;
            r_out.row_end    <= last_col;
            r_out.image_end  <= last_row;
            r_out.bad_filter <= r_filter > FILT_PAETH;
        end
    end

    // The last data byte of a row leaves the block waiting for a filter byte
    a_row_end_awaits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && !r_await && last_col |=> r_await)
        else $error("row end did not return to filter-byte wait");

    // A filter byte opens the row at column zero
    a_filter_opens_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_await |=> !r_await && r_col == '0)
        else $error("filter byte did not open the row at column zero");

    // An image end is always a row end
    a_image_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.image_end |-> r_out.row_end)
        else $error("image end without row end");

    // The image end brings the row count back to zero
    a_image_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && !r_await && last_row |=> r_row == '0)
        else $error("row count did not wrap at image end");

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import pngunf_pkg::*;

    localparam int ROW_MAX     = 8192;
    localparam int PIX_MAX     = 8;
    localparam int SETTLE      = 4;
    localparam int STALL_LIMIT = 1000;
    localparam int RAND_ITEMS  = 900;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    pngunf_stream_if #(.T(logic [7:0])) in_if ();
    pngunf_stream_if #(.T(t_out))       out_if ();

    png_scanline_unfilter #(
        .MAX_ROW_BYTES  (ROW_MAX),
        .MAX_PIXEL_BYTES(PIX_MAX)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_if.sink),
        .o_out     (out_if.source)
    );

    // Rebuilds each row from the filtered stream and holds the pixel words still owed
    class row_rebuilder;
        logic [7:0]        prev_row [ROW_MAX];
        logic [63:0]       left_win;
        logic [63:0]       ul_win;
        int unsigned       col_cnt;
        int unsigned       row_cnt;
        logic [7:0]        row_filt;
        bit                await_filt;
        logic [BPP_W-1:0]  bpp_reg;
        logic [ROWB_W-1:0] len_reg;
        logic [ROWS_W-1:0] rows_reg;
        int unsigned       written_len;
        t_out              rebuilt_q[$];
        int                n_errors;

        function new();
            bpp_reg     = BPP_W'(1);
            len_reg     = ROWB_W'(1);
            rows_reg    = ROWS_W'(1);
            left_win    = '0;
            ul_win      = '0;
            col_cnt     = 0;
            row_cnt     = 0;
            row_filt    = '0;
            await_filt  = 1'b1;
            written_len = 0;
            n_errors    = 0;
        endfunction

        function int unsigned pix_bytes();
            if (bpp_reg == 0) return 1;
            if (bpp_reg > PIX_MAX) return PIX_MAX;
            return 32'(bpp_reg);
        endfunction

        function int unsigned row_len_of(int unsigned v);
            if (v == 0) return 1;
            if (v > ROW_MAX) return ROW_MAX;
            return v;
        endfunction

        function int unsigned row_len();
            return row_len_of(32'(len_reg));
        endfunction

        function int unsigned img_rows();
            return (rows_reg == 0) ? 1 : 32'(rows_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_BPP:        bpp_reg  = val[BPP_W-1:0];
                CFG_ROW_BYTES:  len_reg  = val[ROWB_W-1:0];
                CFG_IMAGE_ROWS: rows_reg = val[ROWS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
            int ia, ib, ic, p, da, db, dc;
            ia = int'(a);
            ib = int'(b);
            ic = int'(c);
            p  = ia + ib - ic;
            da = (p > ia) ? p - ia : ia - p;
            db = (p > ib) ? p - ib : ib - p;
            dc = (p > ic) ? p - ic : ic - p;
            if (da <= db && da <= dc) return a;
            if (db <= dc) return b;
            return c;
        endfunction

        // Note one accepted stream word
        function void take_stream_byte(logic [7:0] x);
            int unsigned bpp, len, rows, col;
            logic [7:0]  a, b, c, pred, r;
            logic [8:0]  sum;
            bit          last_col, last_row;
            t_out        want;
            if (await_filt) begin
                row_filt   = x;
                col_cnt    = 0;
                left_win   = '0;
                ul_win     = '0;
                await_filt = 1'b0;
                return;
            end
            bpp  = pix_bytes();
            len  = row_len();
            rows = img_rows();
            col  = (col_cnt >= ROW_MAX) ? ROW_MAX - 1 : col_cnt;

            // Left and upper-left come from the windows once a full pixel is behind us
            if (col >= bpp) begin
                a = left_win[(bpp - 1) * 8 +: 8];
                c = ul_win[(bpp - 1) * 8 +: 8];
            end else begin
                a = '0;
                c = '0;
            end
            b = (row_cnt > 0) ? prev_row[col] : 8'h00;
            if (row_cnt == 0) c = '0;

            case (row_filt)
                FILT_NONE:  pred = '0;
                FILT_SUB:   pred = a;
                FILT_UP:    pred = b;
                FILT_AVG: begin
                    sum  = {1'b0, a} + {1'b0, b};
                    pred = sum[8:1];
                end
                FILT_PAETH: pred = paeth_pick(a, b, c);
                default:    pred = '0;
            endcase
            r = x + pred;

            prev_row[col] = r;
            if (col + 1 > written_len) written_len = col + 1;
            left_win = {left_win[55:0], r};
            ul_win   = {ul_win[55:0], b};

            // Advance column, row and image
            last_col = (col + 1 >= len);
            last_row = 1'b0;
            if (last_col) begin
                await_filt = 1'b1;
                col_cnt    = 0;
                last_row   = (row_cnt + 1 >= rows);
                row_cnt    = last_row ? 0 : row_cnt + 1;
            end else begin
                col_cnt = col + 1;
            end

            want.out_byte   = r;
            want.row_end    = last_col;
            want.image_end  = last_row;
            want.bad_filter = (row_filt > FILT_PAETH);
            rebuilt_q.push_back(want);
        endfunction

        function void flag(string what, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: %s expected %h got %h", $time, what, want, got);
            end
        endfunction

        // Check one result word against the oldest owed pixel
        function void check_rebuilt(t_out got);
            t_out want;
            if (rebuilt_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 40)
                    $display("%0t: unexpected word, expected none got %p", $time, got);
                return;
            end
            want = rebuilt_q.pop_front();
            flag("out_byte", want.out_byte, got.out_byte);
            flag("row_end", 8'(want.row_end), 8'(got.row_end));
            flag("image_end", 8'(want.image_end), 8'(got.image_end));
            flag("bad_filter", 8'(want.bad_filter), 8'(got.bad_filter));
        endfunction
    endclass

    row_rebuilder board;
    bit           idle_en = 1'b1;
    int           n_items = 0;
    int           quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    // Monitor both channels and watch for a hang
    always @(posedge i_clk) begin
        if (in_if.valid && in_if.ready) board.take_stream_byte(in_if.data);
        if (out_if.valid && out_if.ready) board.check_rebuilt(out_if.data);
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Output side: ready with random stall bursts
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            if (idle_en && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Send one stream word, with an optional gap in front
    task automatic send_byte(input logic [7:0] b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= b;
        do @(posedge i_clk); while (!in_if.ready);
        n_items++;
    endtask

    // Hold the sender until every owed word is back and the pipe is empty
    task automatic wait_quiet();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.rebuilt_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write the registers picked by mask while the block is idle
    task automatic set_regs(input bit [2:0] mask, input logic [BPP_W-1:0] bpp,
                            input logic [ROWB_W-1:0] len, input logic [ROWS_W-1:0] rows);
        logic [CFG_IDX_W-1:0] idxs[3];
        logic [CFG_W-1:0]     vals[3];
        logic [ROWB_W-1:0]    safe_len;
        wait_quiet();
        // Never let a row read past what the line store holds
        safe_len = len;
        if (board.row_cnt != 0 && board.row_len_of(32'(len)) > board.written_len)
            safe_len = ROWB_W'(board.written_len);
        idxs = '{CFG_BPP, CFG_ROW_BYTES, CFG_IMAGE_ROWS};
        vals = '{CFG_W'(bpp), CFG_W'(safe_len), CFG_W'(rows)};
        for (int i = 0; i < 3; i++) begin
            if (mask[i]) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= idxs[i];
                i_cfg_data <= vals[i];
                @(posedge i_clk);
                board.write_reg(idxs[i], vals[i]);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_regs();
        logic [BPP_W-1:0]  bpp;
        logic [ROWB_W-1:0] len;
        logic [ROWS_W-1:0] rows;
        int r;
        r    = $urandom_range(0, 9);
        bpp  = (r < 3) ? BPP_W'($urandom_range(0, 15)) : BPP_W'($urandom_range(1, 8));
        r    = $urandom_range(0, 19);
        len  = (r == 0) ? ROWB_W'(0) : (r == 1) ? ROWB_W'($urandom_range(49, 128)) :
               (r < 5) ? ROWB_W'($urandom_range(17, 48)) : ROWB_W'($urandom_range(1, 16));
        r    = $urandom_range(0, 9);
        rows = (r == 0) ? ROWS_W'(0) : (r == 1) ? 16'hFFFF : ROWS_W'($urandom_range(1, 5));
        set_regs(3'($urandom_range(1, 7)), bpp, len, rows);
    endtask

    // One row: filter word, then data words; sometimes change registers mid-row
    task automatic send_row(input bit allow_change);
        logic [7:0]  filt;
        int unsigned k, left, stop_at, len;
        len     = board.row_len();
        filt    = ($urandom_range(0, 19) < 17) ? 8'($urandom_range(0, 4))
                                                : 8'($urandom_range(5, 255));
        stop_at = (allow_change && $urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1)
                                                               : len + 1;
        send_byte(filt);
        left = len;
        k    = 0;
        while (left > 0) begin
            if (k == stop_at) begin
                random_regs();
                len  = board.row_len();
                left = (k + 1 >= len) ? 1 : len - k;
            end
            send_byte(8'($urandom_range(0, 255)));
            k++;
            left--;
        end
    endtask

    initial begin
        logic [7:0] seq_a[];
        logic [7:0] seq_b[];
        logic [7:0] seq_c[];
        int         goal;
        seq_a = '{FILT_NONE, 8'hFF, 8'hFF, 8'h00};
        seq_b = '{FILT_SUB, 8'h7F};
        seq_c = '{FILT_NONE, 8'hFF, 8'h01, 8'h80,
                  FILT_SUB, 8'h00, 8'hFF, 8'h01,
                  FILT_UP, 8'h01, 8'h00, 8'hFF,
                  FILT_AVG, 8'hFF, 8'hFF, 8'h7F,
                  FILT_PAETH, 8'h00, 8'h80, 8'hFF};

        board       = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_BPP;
        i_cfg_data  <= '0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: single-byte rows, unknown filter 255 passes through
        foreach (seq_a[i]) send_byte(seq_a[i]);
        // All registers zero act as one
        set_regs(3'b111, BPP_W'(0), ROWB_W'(0), ROWS_W'(0));
        foreach (seq_b[i]) send_byte(seq_b[i]);
        // Every filter over a five-row image, extreme data
        set_regs(3'b111, BPP_W'(2), ROWB_W'(3), ROWS_W'(5));
        foreach (seq_c[i]) send_byte(seq_c[i]);

        // Widest pixel from an out-of-range register value
        set_regs(3'b111, 4'hF, ROWB_W'(20), ROWS_W'(1));
        send_row(1'b0);

        // Random phases of well-formed rows
        goal = n_items + RAND_ITEMS;
        while (n_items < goal) begin
            idle_en = (n_items > goal - 150) ? 1'b0 : ($urandom_range(0, 3) != 0);
            random_regs();
            repeat ($urandom_range(1, 6)) begin
                send_row(1'b1);
                if ($urandom_range(0, 19) == 0) wait_quiet();
            end
        end

        wait_quiet();
        repeat (SETTLE) @(posedge i_clk);
        if (board.rebuilt_q.size() != 0) begin
            board.n_errors++;
            $display("%0t: %0d words expected, none received", $time, board.rebuilt_q.size());
        end
        if (board.n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/pngunf_pkg.sv
rtl/pngunf_stream_if.sv
rtl/pngunf_pred.sv
rtl/pngunf_line.sv
rtl/png_scanline_unfilter.sv
verif/tb.sv
